>>> hw/rtl/swdl_pkg.sv
// shared types and constants of the sliding window damage limiter
// no dependencies; used by swdl_cell, swdl_chain and sliding_window_damage_limiter
`default_nettype none

package swdl_pkg;

    localparam int STAMP_W  = 32;
    localparam int WINDOW_W = 16;
    localparam int LIMIT_W  = 6;
    localparam int DELAY_W  = 16;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_RETRY_MS = 2'd2;

    // reset values of the registers
    localparam logic [WINDOW_W-1:0] WINDOW_MS_RST     = 16'd1000;
    localparam logic [LIMIT_W-1:0]  EVENT_LIMIT_RST   = 6'd30;
    localparam logic [DELAY_W-1:0]  BUSY_RETRY_MS_RST = 16'd100;

    localparam logic [DELAY_W-1:0] DELAY_SAT = '1;

    typedef enum logic [1:0] {
        VERDICT_FREE     = 2'd0,
        VERDICT_RECORDED = 2'd1,
        VERDICT_BUSY     = 2'd2,
        VERDICT_RATE     = 2'd3
    } verdict_t;

    // control from the sequencer to the stamp chain
    typedef struct packed {
        logic shift;    // every cell but the top one takes its upper neighbor's stamp; the top cell keeps its own
        logic load;     // the cell at the fill position takes the new stamp
    } chain_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/swdl_cell.sv
// one cell of the timestamp chain: holds one stamp
// depends on swdl_pkg
`default_nettype none

module swdl_cell (
    input  wire logic                          clk,
    input  wire logic                          shift,
    input  wire logic                          load,
    input  wire logic [swdl_pkg::STAMP_W-1:0]  upper_stamp,
    input  wire logic [swdl_pkg::STAMP_W-1:0]  new_stamp,
    output logic      [swdl_pkg::STAMP_W-1:0]  stamp
);

    logic [swdl_pkg::STAMP_W-1:0] stamp_reg;
    logic [swdl_pkg::STAMP_W-1:0] stamp_next;

    always_comb
    begin
        stamp_next = stamp_reg;
        if (shift)
        begin
            stamp_next = upper_stamp;
        end
        else if (load)
        begin
            stamp_next = new_stamp;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
    end

    assign stamp = stamp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/swdl_chain.sv
// row of stamp cells, oldest stamp in cell 0, shifting toward it on expiry
// depends on swdl_pkg and swdl_cell
`default_nettype none

module swdl_chain #(
    parameter int DEPTH = 32,
    parameter int CW    = 6
) (
    input  wire logic                          clk,
    input  wire swdl_pkg::chain_ctrl_t         ctrl,
    input  wire logic [CW-1:0]                 count,
    input  wire logic [swdl_pkg::STAMP_W-1:0]  new_stamp,
    output logic      [swdl_pkg::STAMP_W-1:0]  head_stamp
);

    logic [swdl_pkg::STAMP_W-1:0] cell_stamp [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [swdl_pkg::STAMP_W-1:0] upper;
        logic                         sel;

        if (i == DEPTH - 1)
        begin : g_top
            assign upper = cell_stamp[i];
        end
        else
        begin : g_mid
            assign upper = cell_stamp[i+1];
        end

        // the fill position is the first free cell
        assign sel = ctrl.load && (count == CW'(i));

        swdl_cell u_cell (
            .clk         (clk),
            .shift       (ctrl.shift),
            .load        (sel),
            .upper_stamp (upper),
            .new_stamp   (new_stamp),
            .stamp       (cell_stamp[i])
        );
    end

    assign head_stamp = cell_stamp[0];

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_damage_limiter.sv
// top level of the sliding window damage limiter: sequencer, registers, output stage
// depends on swdl_pkg and swdl_chain (which holds swdl_cell)
//
//  channel   dir  handshake         payload
//  s_*       in   s_tvalid/tready   tdata: stamp_ms[31:0]; tuser: in_transition, animation_busy
//  m_*       out  m_tvalid/tready   tdata: retry_delay_ms[15:0]; tuser: verdict[1:0]
//  cfg_*     in   cfg_we            cfg_index selects register, cfg_data holds value
//
// a beat that is not transitioning, or is busy, goes from S_IDLE straight to S_RESP; any other
// beat goes through S_EXPIRE, which pops one stamp a cycle off the head of the cell chain, then
// S_DECIDE, which records the stamp or defers it, and S_RESP, which loads the output register
// reset empties the history (count cleared); cell contents are never read unless written
// a stalled output holds its result; the next input beat is taken while it waits
`default_nettype none

module sliding_window_damage_limiter #(
    parameter int HISTORY_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] stamp_ms
    input  wire logic [1:0]  s_tuser,   // [0] in_transition, [1] animation_busy
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] retry_delay_ms
    output logic [1:0]       m_tuser,   // [1:0] verdict
    // configuration
    input  wire logic                             cfg_we,
    input  wire logic [swdl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [swdl_pkg::WINDOW_W-1:0]    cfg_data
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int LW = (CW > swdl_pkg::LIMIT_W) ? CW : swdl_pkg::LIMIT_W;
    localparam int SW = swdl_pkg::STAMP_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXPIRE = 4'b0010,
        S_DECIDE = 4'b0100,
        S_RESP   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [swdl_pkg::WINDOW_W-1:0] window_ms_reg;
    logic [swdl_pkg::LIMIT_W-1:0]  event_limit_reg;
    logic [swdl_pkg::DELAY_W-1:0]  busy_retry_ms_reg;

    // history fill level
    logic [CW-1:0] count_reg, count_next;

    // latched input beat
    logic [SW-1:0] now_reg, now_next;

    // pending result
    swdl_pkg::verdict_t            res_verdict_reg, res_verdict_next;
    logic [swdl_pkg::DELAY_W-1:0]  res_delay_reg, res_delay_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    swdl_pkg::verdict_t            m_verdict_reg, m_verdict_next;
    logic [swdl_pkg::DELAY_W-1:0]  m_delay_reg, m_delay_next;

    swdl_pkg::chain_ctrl_t chain_ctrl;
    logic [SW-1:0]         head_stamp;

    logic          in_beat;
    logic [SW:0]   expire_at;     // oldest stamp plus window, one bit wider
    logic          head_expired;
    logic [SW:0]   expire_gap;
    logic [LW-1:0] limit_raw;
    logic [LW-1:0] limit_eff;
    logic          at_limit;

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    assign expire_at    = {1'b0, head_stamp} + (SW+1)'(window_ms_reg);
    assign head_expired = (count_reg != '0) && (expire_at < {1'b0, now_reg});
    assign expire_gap   = expire_at - {1'b0, now_reg};

    // a limit of zero acts as one, above the depth acts as the depth
    assign limit_raw = LW'(event_limit_reg);
    always_comb
    begin
        limit_eff = limit_raw;
        if (limit_raw == '0)
        begin
            limit_eff = LW'(1);
        end
        else if (limit_raw > LW'(HISTORY_DEPTH))
        begin
            limit_eff = LW'(HISTORY_DEPTH);
        end
    end
    assign at_limit = (LW'(count_reg) >= limit_eff);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg     <= swdl_pkg::WINDOW_MS_RST;
            event_limit_reg   <= swdl_pkg::EVENT_LIMIT_RST;
            busy_retry_ms_reg <= swdl_pkg::BUSY_RETRY_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swdl_pkg::CFG_WINDOW_MS:
                    window_ms_reg <= cfg_data;
                swdl_pkg::CFG_EVENT_LIMIT:
                    event_limit_reg <= cfg_data[swdl_pkg::LIMIT_W-1:0];
                swdl_pkg::CFG_BUSY_RETRY_MS:
                    busy_retry_ms_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        now_next         = now_reg;
        res_verdict_next = res_verdict_reg;
        res_delay_next   = res_delay_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_verdict_next   = m_verdict_reg;
        m_delay_next     = m_delay_reg;
        chain_ctrl       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    now_next = s_tdata;
                    if (!s_tuser[0])
                    begin
                        // leaving transition empties the history
                        count_next       = '0;
                        res_verdict_next = swdl_pkg::VERDICT_FREE;
                        res_delay_next   = '0;
                        state_next       = S_RESP;
                    end
                    else if (s_tuser[1])
                    begin
                        res_verdict_next = swdl_pkg::VERDICT_BUSY;
                        res_delay_next   = busy_retry_ms_reg;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        state_next = S_EXPIRE;
                    end
                end
            end
            S_EXPIRE:
            begin
                // pop one expired stamp per cycle
                if (head_expired)
                begin
                    chain_ctrl.shift = 1'b1;
                    count_next       = count_reg - CW'(1);
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (at_limit)
                begin
                    res_verdict_next = swdl_pkg::VERDICT_RATE;
                    if (expire_gap[SW:swdl_pkg::DELAY_W] != '0)
                    begin
                        res_delay_next = swdl_pkg::DELAY_SAT;
                    end
                    else
                    begin
                        res_delay_next = expire_gap[swdl_pkg::DELAY_W-1:0];
                    end
                end
                else
                begin
                    chain_ctrl.load  = 1'b1;
                    count_next       = count_reg + CW'(1);
                    res_verdict_next = swdl_pkg::VERDICT_RECORDED;
                    res_delay_next   = '0;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next   = 1'b1;
                    m_verdict_next = res_verdict_reg;
                    m_delay_next   = res_delay_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        res_verdict_reg <= res_verdict_next;
        res_delay_reg   <= res_delay_next;
        m_verdict_reg   <= m_verdict_next;
        m_delay_reg     <= m_delay_next;
    end

    swdl_chain #(
        .DEPTH (HISTORY_DEPTH),
        .CW    (CW)
    ) u_chain (
        .clk        (clk),
        .ctrl       (chain_ctrl),
        .count      (count_reg),
        .new_stamp  (now_reg),
        .head_stamp (head_stamp)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_delay_reg;
    assign m_tuser  = m_verdict_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HISTORY_DEPTH))
        else $error("history count above depth");

    a_shift_only_expire: assert property (@(posedge clk) disable iff (!rst_n)
        chain_ctrl.shift |-> (state_reg == S_EXPIRE) && (count_reg != '0))
        else $error("chain shift outside expiry or on empty history");

    a_record_grows: assert property (@(posedge clk) disable iff (!rst_n)
        chain_ctrl.load |=> count_reg == $past(count_reg) + CW'(1))
        else $error("record did not grow the history");

    a_rate_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && at_limit) |-> count_reg != '0)
        else $error("rate deferral on an empty history");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken while an item is in work");
`endif

endmodule

`default_nettype wire

>>> tb/sv/swdl_verdict_checker.sv
// checker for the sliding window damage limiter: watches the config port and both streams,
// predicts each verdict and retry delay, and compares beat by beat
// depends on swdl_pkg for widths, register indexes and the verdict enum
module swdl_verdict_checker
    import swdl_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] stamp_ms
    input  logic [1:0]           s_tuser,   // [0] in_transition, [1] animation_busy
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [15:0]          m_tdata,   // [15:0] retry_delay_ms
    input  logic [1:0]           m_tuser,   // [1:0] verdict
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WINDOW_W-1:0]  cfg_data,
    output int                   outstanding,
    output int                   errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        verdict_t           verdict;
        logic [DELAY_W-1:0] delay;
    } ruling_t;

    // shadow of the block's registers and stamp history
    logic [STAMP_W-1:0]  stamp_ring [HISTORY_DEPTH];
    int unsigned         ring_head;
    int unsigned         ring_fill;
    logic [WINDOW_W-1:0] window_ms;
    logic [LIMIT_W-1:0]  event_limit;
    logic [DELAY_W-1:0]  busy_retry_ms;

    ruling_t verdicts_due [$];

    function automatic ruling_t judge_event(logic [STAMP_W-1:0] now, logic transitioning,
                                            logic busy);
        ruling_t     r;
        logic [32:0] expire;
        logic [32:0] wait_ms;
        int unsigned cap;
        r.verdict = VERDICT_FREE;
        r.delay   = '0;
        if (!transitioning)
        begin
            ring_fill = 0;
            ring_head = 0;
        end
        else if (busy)
        begin
            r.verdict = VERDICT_BUSY;
            r.delay   = busy_retry_ms;
        end
        else
        begin
            // drop stamps that fell out of the window, oldest first
            while (ring_fill > 0 &&
                   ({1'b0, stamp_ring[ring_head]} + 33'(window_ms)) < {1'b0, now})
            begin
                ring_head = (ring_head + 1) % HISTORY_DEPTH;
                ring_fill--;
            end
            cap = (event_limit == 0) ? 1 :
                  (event_limit > HISTORY_DEPTH) ? HISTORY_DEPTH : event_limit;
            if (ring_fill >= cap)
            begin
                expire    = {1'b0, stamp_ring[ring_head]} + 33'(window_ms);
                wait_ms   = expire - {1'b0, now};
                r.verdict = VERDICT_RATE;
                r.delay   = (wait_ms > 33'(DELAY_SAT)) ? DELAY_SAT : wait_ms[DELAY_W-1:0];
            end
            else
            begin
                stamp_ring[(ring_head + ring_fill) % HISTORY_DEPTH] = now;
                ring_fill++;
                r.verdict = VERDICT_RECORDED;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ruling_t due;
        if (!rst_n)
        begin
            ring_head     = 0;
            ring_fill     = 0;
            window_ms     = WINDOW_MS_RST;
            event_limit   = EVENT_LIMIT_RST;
            busy_retry_ms = BUSY_RETRY_MS_RST;
            verdicts_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_MS:     window_ms     = cfg_data;
                    CFG_EVENT_LIMIT:   event_limit   = cfg_data[LIMIT_W-1:0];
                    CFG_BUSY_RETRY_MS: busy_retry_ms = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                verdicts_due.insert(verdicts_due.size(),
                                    judge_event(s_tdata, s_tuser[0], s_tuser[1]));
            if (m_tvalid && m_tready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("unexpected result beat: verdict %0d, retry_delay_ms %0d",
                           m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (m_tuser !== due.verdict)
                    begin
                        $error("verdict: expected %s (%0d), got %0d",
                               due.verdict.name(), due.verdict, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== due.delay)
                    begin
                        $error("retry_delay_ms: expected %0d, got %0d", due.delay, m_tdata);
                        errors++;
                    end
                end
            end
            outstanding <= verdicts_due.size();
        end
    end

endmodule

>>> tb/sv/sliding_window_damage_limiter_tb.sv
// top of the sliding window damage limiter testbench: clock, reset, stimulus and verdict
// depends on swdl_pkg, the block sliding_window_damage_limiter and swdl_verdict_checker
module sliding_window_damage_limiter_tb;
    import swdl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HISTORY_DEPTH = 32;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_EVENTS  = 108;
    // the limit leaves a wide margin over a run with the largest gap and stall on every item
    localparam int LIMIT_CYCLES  = 600_000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;   // [31:0] stamp_ms
    logic [1:0]           s_tuser;   // [0] in_transition, [1] animation_busy
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;   // [15:0] retry_delay_ms
    logic [1:0]           m_tuser;   // [1:0] verdict
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WINDOW_W-1:0]  cfg_data;

    int outstanding;
    int errors;
    int cycle_cnt;
    int events_sent;
    int settings_used;
    bit send_fast;     // sender runs back to back in this phase
    bit recv_fast;     // receiver never stalls in this phase

    sliding_window_damage_limiter #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    swdl_verdict_checker #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .outstanding(outstanding),
        .errors(errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one damage event beat; leaves tvalid high so the next beat can follow directly
    task automatic send_event(input logic [31:0] stamp, input logic transitioning,
                              input logic busy);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= stamp;
        s_tuser  <= {busy, transitioning};
        do @(posedge clk); while (!s_tready);
        events_sent++;
    endtask

    // stop sending, wait for every verdict to come back, then let the sequencer settle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (HISTORY_DEPTH + 8) @(posedge clk);
    endtask

    // all three registers back to back, only called while the block is idle
    task automatic write_regs(input logic [15:0] win, input logic [15:0] lim,
                              input logic [15:0] retry);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WINDOW_MS;
        cfg_data  <= win;
        @(posedge clk);
        cfg_index <= CFG_EVENT_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_index <= CFG_BUSY_RETRY_MS;
        cfg_data  <= retry;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // receiver: random stall before each result beat, no stall in fast phases
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = recv_fast ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // watchdog
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d verdicts still due", cycle_cnt, outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [15:0] win;
        logic [5:0]  lim6;
        logic [15:0] retry;
        logic [31:0] now_ms;
        int          lim_eff;
        int          step_max;
        int          pick;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_WINDOW_MS;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        send_fast = 1'b0;
        recv_fast = 1'b0;
        events_sent   = 0;
        settings_used = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values (window 1000, limit 30, retry 100)
        send_event(32'd0, 1'b0, 1'b0);            // not transitioning
        send_event(32'd5, 1'b0, 1'b1);            // busy ignored when not transitioning
        send_event(32'hFFFF_FFFF, 1'b1, 1'b1);    // busy deferral, top stamp
        send_event(32'd10, 1'b1, 1'b0);           // recorded
        send_event(32'd20, 1'b1, 1'b0);           // recorded
        send_event(32'hFFFF_FFFF, 1'b1, 1'b0);    // both old stamps expire, then recorded
        send_event(32'd30, 1'b0, 1'b0);           // leaving transition clears history
        settle();

        // smallest window, limit zero behaves as one, zero busy delay
        write_regs(16'd1, 16'd0, 16'd0);
        send_event(32'd1000, 1'b1, 1'b0);         // recorded
        send_event(32'd1001, 1'b1, 1'b0);         // exactly at expiry edge: rate, delay 0
        send_event(32'd1002, 1'b1, 1'b0);         // oldest expires, recorded
        send_event(32'd0, 1'b1, 1'b0);            // stamp before the oldest: rate 1003
        send_event(32'd1002, 1'b1, 1'b1);         // busy with zero retry
        settle();

        // largest window and busy delay, limit one
        write_regs(16'hFFFF, 16'd1, 16'hFFFF);
        send_event(32'd0, 1'b0, 1'b0);            // clear
        send_event(32'h8000_0000, 1'b1, 1'b0);    // recorded
        send_event(32'h8000_0000, 1'b1, 1'b0);    // rate, delay exactly 65535
        send_event(32'd0, 1'b1, 1'b0);            // oldest far ahead: delay saturates
        send_event(32'd5, 1'b1, 1'b1);            // busy, largest retry
        send_event(32'hFFFF_FFFF, 1'b1, 1'b0);    // expiry then recorded
        settle();

        // random phases, each with its own register setting; first ones hit the extremes
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: begin win = 16'hFFFF; lim6 = 6'd32; retry = 16'd0;    end
                1: begin win = 16'd1;    lim6 = 6'd63; retry = 16'hFFFF; end
                2: begin win = 16'd1000; lim6 = 6'd1;  retry = 16'hFFFF; end
                3: begin win = 16'd200;  lim6 = 6'd0;  retry = 16'd0;    end
                4: begin win = 16'd40;   lim6 = 6'd33; retry = 16'd100;  end
                default:
                begin
                    win   = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
                    lim6  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(1, 32));
                    retry = 16'($urandom);
                end
            endcase
            // upper data bits above the limit field are junk the block must drop
            write_regs(win, {10'($urandom), lim6}, retry);

            send_fast = ($urandom_range(0, 3) == 0);
            recv_fast = ($urandom_range(0, 3) == 0);
            lim_eff   = (lim6 == 0) ? 1 : (lim6 > HISTORY_DEPTH) ? HISTORY_DEPTH : lim6;
            // steps sized so the limit is reached and old stamps keep expiring
            step_max  = (2 * int'(win)) / lim_eff + 1;
            now_ms    = $urandom;

            for (int i = 0; i < PHASE_EVENTS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_event($urandom, 1'b0, 1'($urandom_range(0, 1)));
                else if (pick < 9)
                    send_event(now_ms, 1'b1, 1'b1);
                else if (pick < 12)
                    send_event($urandom, 1'b1, 1'($urandom_range(0, 1)));
                else
                begin
                    now_ms = now_ms + 32'($urandom_range(0, step_max));
                    send_event(now_ms, 1'b1, 1'b0);
                end
            end
            settle();
        end

        $display("ran %0d damage events over %0d register settings", events_sent,
                 settings_used + 1);
        $display("windows 1 to 65535 ms, limits 0 to 63, busy and rate deferrals, clears");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
